// File: hw/rtl/lzw_pkg.sv
// Shared types and constants for the LZW compressor.
package lzw_pkg;

	localparam int unsigned SYM_W      = 7;
	localparam int unsigned CODE_W     = 16;
	localparam int unsigned ENTRY_W    = CODE_W + SYM_W;
	localparam int unsigned ROOT_CODES = 128;

	typedef struct packed {
		logic accept;
		logic search_start;
		logic take_hit;
		logic emit_miss;
		logic emit_final;
	} lzw_cmd_t;

	typedef struct packed {
		logic prefix_valid;
		logic hit;
		logic miss;
		logic out_free;
	} lzw_sts_t;

endpackage

// File: hw/rtl/lzw_ctrl.sv
// Controller state machine for the LZW compressor.
module lzw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_last,
	output logic              in_ready,
	input  lzw_pkg::lzw_sts_t sts,
	output lzw_pkg::lzw_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SEARCH = 4'b0010,
		ST_MISS   = 4'b0100,
		ST_FINAL  = 4'b1000
	} lzw_state_t;

	lzw_state_t state_q, state_d;
	logic       last_q;
	logic       acc;

	assign in_ready = (state_q == ST_IDLE);
	assign acc      = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					cmd.accept = 1'b1;
					if (sts.prefix_valid) begin
						cmd.search_start = 1'b1;
						state_d          = ST_SEARCH;
					end else if (in_last) begin
						state_d = ST_FINAL;
					end
				end
			end
			ST_SEARCH: begin
				if (sts.hit) begin
					cmd.take_hit = 1'b1;
					state_d      = last_q ? ST_FINAL : ST_IDLE;
				end else if (sts.miss) begin
					state_d = ST_MISS;
				end
			end
			ST_MISS: begin
				if (sts.out_free) begin
					cmd.emit_miss = 1'b1;
					state_d       = last_q ? ST_FINAL : ST_IDLE;
				end
			end
			ST_FINAL: begin
				if (sts.out_free) begin
					cmd.emit_final = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc) last_q <= in_last;
		end
	end

endmodule

// File: hw/rtl/lzw_dpath.sv
// Datapath of the LZW compressor: dictionary memory, search, prefix and output register.
module lzw_dpath #(
	parameter int unsigned DICT_DEPTH = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [lzw_pkg::SYM_W-1:0]     in_symbol,
	input  lzw_pkg::lzw_cmd_t             cmd,
	output lzw_pkg::lzw_sts_t             sts,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lzw_pkg::CODE_W-1:0]    out_code,
	output logic                          out_final
);

	localparam int unsigned IDX_W = $clog2(DICT_DEPTH);
	localparam int unsigned CNT_W = $clog2(DICT_DEPTH + 1);

	logic [lzw_pkg::ENTRY_W-1:0] dict_mem [DICT_DEPTH];

	logic [lzw_pkg::SYM_W-1:0]   sym_q;
	logic [lzw_pkg::CODE_W-1:0]  prefix_q;
	logic                        prefix_valid_q;
	logic [CNT_W-1:0]            count_q;
	logic [CNT_W-1:0]            rd_idx_q;
	logic                        pend_s1;
	logic [IDX_W-1:0]            cmp_idx_s1;
	logic [lzw_pkg::ENTRY_W-1:0] rd_data_s1;
	logic                        out_valid_q;
	logic [lzw_pkg::CODE_W-1:0]  out_code_q;
	logic                        out_final_q;

	logic [lzw_pkg::ENTRY_W-1:0] key;
	logic                        full;
	logic                        hit;
	logic                        issue;
	logic                        out_free;
	logic [lzw_pkg::CODE_W-1:0]  hit_code;

	assign key      = {prefix_q, sym_q};
	assign full     = (count_q == CNT_W'(DICT_DEPTH));
	assign hit      = pend_s1 && (rd_data_s1 == key);
	assign issue    = (rd_idx_q < count_q) && !hit;
	assign out_free = !out_valid_q || out_ready;
	assign hit_code = lzw_pkg::CODE_W'(lzw_pkg::ROOT_CODES) + lzw_pkg::CODE_W'(cmp_idx_s1);

	assign sts.prefix_valid = prefix_valid_q;
	assign sts.hit          = hit;
	assign sts.miss         = !pend_s1 && (rd_idx_q >= count_q);
	assign sts.out_free     = out_free;

	assign out_valid = out_valid_q;
	assign out_code  = out_code_q;
	assign out_final = out_final_q;

	always_ff @(posedge clk) begin
		if (cmd.emit_miss && !full) begin
			dict_mem[count_q[IDX_W-1:0]] <= key;
		end
		if (issue) begin
			rd_data_s1 <= dict_mem[rd_idx_q[IDX_W-1:0]];
			cmp_idx_s1 <= rd_idx_q[IDX_W-1:0];
		end
		if (cmd.accept) sym_q <= in_symbol;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q       <= '0;
			prefix_valid_q <= 1'b0;
			count_q        <= '0;
			rd_idx_q       <= '0;
			pend_s1        <= 1'b0;
			out_valid_q    <= 1'b0;
			out_code_q     <= '0;
			out_final_q    <= 1'b0;
		end else begin
			if (cmd.search_start) begin
				rd_idx_q <= '0;
				pend_s1  <= 1'b0;
			end else begin
				pend_s1 <= issue;
				if (issue) rd_idx_q <= rd_idx_q + CNT_W'(1);
			end

			if (cmd.accept && !prefix_valid_q) begin
				prefix_q       <= lzw_pkg::CODE_W'(in_symbol);
				prefix_valid_q <= 1'b1;
			end
			if (cmd.take_hit) prefix_q <= hit_code;
			if (cmd.emit_miss) begin
				prefix_q <= lzw_pkg::CODE_W'(sym_q);
				if (!full) count_q <= count_q + CNT_W'(1);
			end
			if (cmd.emit_final) begin
				prefix_q       <= '0;
				prefix_valid_q <= 1'b0;
				count_q        <= '0;
			end

			if (cmd.emit_miss || cmd.emit_final) begin
				out_valid_q <= 1'b1;
				out_code_q  <= prefix_q;
				out_final_q <= cmd.emit_final;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: hw/rtl/lzw_compressor.sv
// Top level of the LZW compressor: stream ports around controller and datapath.
//
//   channel   dir   tdata             tlast
//   s_*       in    [6:0] symbol      last
//   m_*       out   [15:0] code       final_res
//
// The first symbol of a stream needs no search. Every later symbol searches the
// dictionary through its single read port, one entry per cycle, until a hit or the
// entry count (at most DICT_DEPTH entries); each miss and each stream end sends a code.
// Reset empties the dictionary at once through its entry count; no clearing pass.
// A stalled m_tready holds the block in its emit state; s_tready waits for it.
module lzw_compressor #(
	parameter int unsigned DICT_DEPTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [6:0] symbol, [7] zero
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] code
	output logic        m_tlast
);

	lzw_pkg::lzw_cmd_t cmd;
	lzw_pkg::lzw_sts_t sts;

	lzw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lzw_dpath #(
		.DICT_DEPTH (DICT_DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_symbol (s_tdata[lzw_pkg::SYM_W-1:0]),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_code  (m_tdata),
		.out_final (m_tlast)
	);

endmodule

// File: tb/sv/tb.sv
// Testbench for lzw_compressor: directed and random symbol streams checked against an LZW predictor.
module tb;

	localparam int unsigned DICT_DEPTH  = 16;
	localparam int          STALL_LIMIT = 4000;
	localparam int          HOLD_CYCLES = 300;

	typedef struct packed {
		logic [lzw_pkg::CODE_W-1:0] code;
		logic                       fin;
	} code_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // [6:0] symbol, [7] zero
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // [15:0] code
	logic        m_tlast;

	logic [lzw_pkg::ENTRY_W-1:0] dict_mem [DICT_DEPTH];
	int                          n_entries;
	logic [lzw_pkg::CODE_W-1:0]  cur_prefix;
	bit                          have_prefix;
	code_item_t                  pending_codes [$];

	int src_idle_pct;
	int sink_idle_pct;
	int sink_hold;
	int quiet_cycles;
	int errors;
	int n_streams;
	int n_symbols;
	int n_codes;
	int n_hits;
	int n_full_misses;

	lzw_compressor #(
		.DICT_DEPTH(DICT_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch: %s got %0d expected %0d (code %0d)", what, got, want, n_codes);
		errors++;
	endtask

	function automatic void encode_symbol(input logic [lzw_pkg::SYM_W-1:0] sym, input logic lst);
		logic [lzw_pkg::ENTRY_W-1:0] key;
		int                          hit_idx;
		int                          i;
		if (!have_prefix) begin
			cur_prefix = lzw_pkg::CODE_W'(sym);
			have_prefix = 1'b1;
		end else begin
			key = {cur_prefix, sym};
			hit_idx = -1;
			for (i = 0; i < n_entries; i++) begin
				if (hit_idx < 0 && dict_mem[i] == key) begin
					hit_idx = i;
				end
			end
			if (hit_idx >= 0) begin
				cur_prefix = lzw_pkg::CODE_W'(lzw_pkg::ROOT_CODES + hit_idx);
				n_hits++;
			end else begin
				pending_codes.push_back('{cur_prefix, 1'b0});
				if (n_entries < DICT_DEPTH) begin
					dict_mem[n_entries] = key;
					n_entries++;
				end else begin
					n_full_misses++;
				end
				cur_prefix = lzw_pkg::CODE_W'(sym);
			end
		end
		if (lst) begin
			pending_codes.push_back('{cur_prefix, 1'b1});
			have_prefix = 1'b0;
			cur_prefix = '0;
			n_entries = 0;
		end
	endfunction

	task automatic send_symbol(input logic [lzw_pkg::SYM_W-1:0] sym, input logic lst);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {1'b0, sym};
		s_tlast = lst;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		encode_symbol(sym, lst);
		n_symbols++;
		if (lst) n_streams++;
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (sink_hold > 0) begin
			m_tready = 1'b0;
			sink_hold--;
		end else begin
			m_tready = ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	always @(posedge clk) begin
		code_item_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_codes.size() == 0) begin
				report_mismatch("code with none pending", int'(m_tdata), -1);
			end else begin
				want = pending_codes.pop_front();
				if (m_tdata !== want.code) begin
					report_mismatch("code", int'(m_tdata), int'(want.code));
				end
				if (m_tlast !== want.fin) begin
					report_mismatch("final flag", int'(m_tlast), int'(want.fin));
				end
			end
			n_codes++;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no transfer in %0d cycles", STALL_LIMIT);
			$display("status: fail");
			$finish;
		end
	end

	task automatic test_single_symbol;
		send_symbol(7'd0, 1'b1);
	endtask

	task automatic test_repeats;
		int i;
		for (i = 0; i < 5; i++) send_symbol(7'd127, i == 4);
		for (i = 0; i < 3; i++) send_symbol(7'd0, i == 2);
	endtask

	task automatic test_dictionary_full;
		int i;
		for (i = 0; i < DICT_DEPTH + 2; i++) send_symbol(7'(i * 5 + 3), i == DICT_DEPTH + 1);
	endtask

	task automatic test_random_streams(input int src_pct, input int sink_pct, input int n_items);
		int          left;
		int          len;
		int          base;
		int          i;
		bit          narrow;
		logic [6:0]  sym;
		src_idle_pct = src_pct;
		sink_idle_pct = sink_pct;
		left = n_items;
		while (left > 0) begin
			len = $urandom_range(1, 24);
			if (len > left) len = left;
			narrow = ($urandom_range(0, 3) != 0);
			base = $urandom_range(0, 124);
			for (i = 0; i < len; i++) begin
				sym = narrow ? 7'(base + $urandom_range(0, 3)) : 7'($urandom_range(0, 127));
				send_symbol(sym, i == len - 1);
			end
			left -= len;
		end
	endtask

	task automatic test_backpressure;
		int i;
		src_idle_pct = 0;
		sink_idle_pct = 0;
		sink_hold = HOLD_CYCLES;
		for (i = 0; i < 20; i++) send_symbol(7'($urandom_range(60, 62)), i == 19);
	endtask

	initial begin
		src_idle_pct = 19;
		sink_idle_pct = 68;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_single_symbol();
		test_repeats();
		test_dictionary_full();
		test_random_streams(19, 68, 35);
		test_random_streams(68, 19, 35);
		test_random_streams(0, 0, 25);
		test_backpressure();

		s_tvalid = 1'b0;
		sink_idle_pct = 0;
		while (pending_codes.size() != 0) @(posedge clk);
		repeat (DICT_DEPTH + 10) @(posedge clk);

		$display("covered %0d streams, %0d symbols, %0d codes checked", n_streams, n_symbols,
			n_codes);
		$display("dictionary hits %0d, misses with full dictionary %0d, mismatches %0d", n_hits,
			n_full_misses, errors);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/lzw_pkg.sv
hw/rtl/lzw_ctrl.sv
hw/rtl/lzw_dpath.sv
hw/rtl/lzw_compressor.sv
tb/sv/tb.sv
